>>> sv/chained_token_block_hash_assert.svh
// assertion macros for the chained token block hash
`ifndef CHAINED_TOKEN_BLOCK_HASH_ASSERT_SVH
`define CHAINED_TOKEN_BLOCK_HASH_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define CTBH_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ctbh assertion failed");

// antecedent implies consequent in the next cycle
`define CTBH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ctbh assertion failed");

`else

`define CTBH_ASSERT_SAME(lbl, ante, cons)
`define CTBH_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> sv/ctbh_pkg.sv
// shared types, constants and helpers for the chained token block hash
`default_nettype none

package ctbh_pkg;

   localparam logic [63:0] K_MIX1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] K_MIX2 = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] K_GOLD = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] K_SALT = 64'h632BE59BD9B4E019;

   localparam int unsigned XS_SHIFT   = 33;
   localparam int unsigned FOLD_SHL   = 6;
   localparam int unsigned FOLD_SHR   = 2;
   localparam int unsigned TPB_W      = 9;
   localparam int unsigned BLK_IDX_W  = 16;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam logic [TPB_W-1:0] TPB_RESET = 9'd16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TPB  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SALT = 1'b1;

   // datapath operations
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_ACCEPT = 4'd1;
   localparam logic [3:0] OP_SEED_A = 4'd2;
   localparam logic [3:0] OP_SEED_B = 4'd3;
   localparam logic [3:0] OP_SEED_C = 4'd4;
   localparam logic [3:0] OP_TOK1   = 4'd5;
   localparam logic [3:0] OP_TOK2   = 4'd6;
   localparam logic [3:0] OP_MUL    = 4'd7;
   localparam logic [3:0] OP_FIN    = 4'd8;

   typedef struct packed {
      logic [31:0] token;
      logic        seq_start;
   } req_type;

   typedef struct packed {
      logic [63:0]          block_hash;
      logic [BLK_IDX_W-1:0] block_index;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] mphase;
      logic       k_sel;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic out_free;
   } status_type;

   function automatic logic [63:0] xs33(input logic [63:0] x);
      return x ^ (x >> XS_SHIFT);
   endfunction

endpackage

`default_nettype wire

>>> sv/ctbh_dpath.sv
// datapath: hash state, shared 32x32 multiplier, counters and result register
`default_nettype none

module ctbh_dpath #(
   parameter int MAX_BLOCK_TOKENS = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ctbh_pkg::cmd_type                    cmd,
   output ctbh_pkg::status_type                      status,
   input  wire ctbh_pkg::req_type                    req_payload,
   input  wire logic                                 csr_we,
   input  wire logic [ctbh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [63:0]                          csr_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output ctbh_pkg::rsp_type                         rsp_payload
);

   localparam int unsigned TW = ctbh_pkg::TPB_W;
   localparam int unsigned BW = ctbh_pkg::BLK_IDX_W;

   logic [TW-1:0] tpb_ff, tpb_in;
   logic [63:0]   salt_ff, salt_in;
   logic [63:0]   chain_ff, chain_in;
   logic [TW-1:0] cnt_ff, cnt_in;
   logic [BW-1:0] blocks_ff, blocks_in;
   logic [63:0]   h_ff, h_in;
   logic [63:0]   v_ff, v_in;
   logic [63:0]   seed_ff, seed_in;
   logic [63:0]   tmp_ff, tmp_in;
   logic [63:0]   tokg_ff, tokg_in;
   logic [63:0]   acc_ff, acc_in;
   logic [63:0]   mult_ff, mult_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ctbh_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [63:0]   kconst;
   logic [31:0]   mul_a, mul_b;
   logic [63:0]   prod;
   logic [TW-1:0] eff;
   logic [TW:0]   cnt_next;
   logic [63:0]   fin_hash;

   // effective block size: zero reads as one, clamp at the maximum
   always_comb begin
      if (tpb_ff == '0) begin
         eff = TW'(1);
      end else if (32'(tpb_ff) > 32'(MAX_BLOCK_TOKENS)) begin
         eff = TW'(MAX_BLOCK_TOKENS);
      end else begin
         eff = tpb_ff;
      end
   end

   assign kconst = cmd.k_sel ? ctbh_pkg::K_MIX2 : ctbh_pkg::K_MIX1;

   // low 64 bits of v*k from three 32x32 partial products
   always_comb begin
      case (cmd.mphase)
         2'd1: begin
            mul_a = v_ff[31:0];
            mul_b = kconst[63:32];
         end
         2'd2: begin
            mul_a = v_ff[63:32];
            mul_b = kconst[31:0];
         end
         default: begin
            mul_a = v_ff[31:0];
            mul_b = kconst[31:0];
         end
      endcase
   end

   assign prod     = {32'd0, mul_a} * {32'd0, mul_b};
   assign cnt_next = {1'b0, cnt_ff} + (TW+1)'(1);
   assign fin_hash = (v_ff == '0) ? 64'd1 : v_ff;

   always_comb begin
      tpb_in       = tpb_ff;
      salt_in      = salt_ff;
      chain_in     = chain_ff;
      cnt_in       = cnt_ff;
      blocks_in    = blocks_ff;
      h_in         = h_ff;
      v_in         = v_ff;
      seed_in      = seed_ff;
      tmp_in       = tmp_ff;
      tokg_in      = tokg_ff;
      acc_in       = acc_ff;
      mult_in      = mult_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            ctbh_pkg::CSR_TPB:  tpb_in  = csr_data[TW-1:0];
            ctbh_pkg::CSR_SALT: salt_in = csr_data;
            default: ;
         endcase
      end

      case (cmd.op)
         ctbh_pkg::OP_ACCEPT: begin
            if (req_payload.seq_start) begin
               chain_in  = '0;
               cnt_in    = '0;
               blocks_in = '0;
            end
            tokg_in = {32'd0, req_payload.token} + ctbh_pkg::K_GOLD;
         end
         ctbh_pkg::OP_SEED_A: begin
            v_in = ctbh_pkg::xs33(chain_ff ^ ctbh_pkg::K_GOLD);
         end
         ctbh_pkg::OP_SEED_B: begin
            seed_in = v_ff;
            v_in    = ctbh_pkg::xs33(salt_ff + ctbh_pkg::K_SALT);
         end
         ctbh_pkg::OP_SEED_C: begin
            h_in = seed_ff ^ v_ff;
         end
         ctbh_pkg::OP_TOK1: begin
            tmp_in = (h_ff << ctbh_pkg::FOLD_SHL) + (h_ff >> ctbh_pkg::FOLD_SHR);
         end
         ctbh_pkg::OP_TOK2: begin
            v_in = ctbh_pkg::xs33(h_ff ^ (tmp_ff + tokg_ff));
         end
         ctbh_pkg::OP_MUL: begin
            case (cmd.mphase)
               2'd0: begin
                  mult_in = prod;
               end
               2'd1: begin
                  acc_in  = mult_ff;
                  mult_in = prod;
               end
               2'd2: begin
                  acc_in  = {acc_ff[63:32] + mult_ff[31:0], acc_ff[31:0]};
                  mult_in = prod;
               end
               default: begin
                  v_in = ctbh_pkg::xs33({acc_ff[63:32] + mult_ff[31:0], acc_ff[31:0]});
               end
            endcase
         end
         ctbh_pkg::OP_FIN: begin
            if (cnt_next >= {1'b0, eff}) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.block_hash  = fin_hash;
               rsp_data_in.block_index = blocks_ff;
               chain_in                = fin_hash;
               blocks_in               = blocks_ff + BW'(1);
               cnt_in                  = '0;
            end else begin
               cnt_in = cnt_next[TW-1:0];
               h_in   = v_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpb_ff       <= ctbh_pkg::TPB_RESET;
         salt_ff      <= '0;
         chain_ff     <= '0;
         cnt_ff       <= '0;
         blocks_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tpb_ff       <= tpb_in;
         salt_ff      <= salt_in;
         chain_ff     <= chain_in;
         cnt_ff       <= cnt_in;
         blocks_ff    <= blocks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff        <= h_in;
      v_ff        <= v_in;
      seed_ff     <= seed_in;
      tmp_ff      <= tmp_in;
      tokg_ff     <= tokg_in;
      acc_ff      <= acc_in;
      mult_ff     <= mult_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.first    = req_payload.seq_start || (cnt_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_data_ff;

endmodule

`default_nettype wire

>>> sv/ctbh_ctrl.sv
// controller: sequences seed, token fold and multiply phases
`default_nettype none

module ctbh_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ctbh_pkg::status_type  status,
   output ctbh_pkg::cmd_type          cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEED_A = 3'd1;
   localparam logic [2:0] S_SEED_B = 3'd2;
   localparam logic [2:0] S_SEED_C = 3'd3;
   localparam logic [2:0] S_TOK1   = 3'd4;
   localparam logic [2:0] S_TOK2   = 3'd5;
   localparam logic [2:0] S_MUL    = 3'd6;
   localparam logic [2:0] S_FIN    = 3'd7;

   localparam logic [1:0] J_SEED_A = 2'd0;
   localparam logic [1:0] J_SEED_B = 2'd1;
   localparam logic [1:0] J_TOK    = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       ksel_ff, ksel_in;
   logic [1:0] job_ff, job_in;

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      ksel_in    = ksel_ff;
      job_in     = job_ff;
      cmd.op     = ctbh_pkg::OP_NONE;
      cmd.mphase = phase_ff;
      cmd.k_sel  = ksel_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = ctbh_pkg::OP_ACCEPT;
               state_in = status.first ? S_SEED_A : S_TOK1;
            end
         end
         S_SEED_A: begin
            cmd.op   = ctbh_pkg::OP_SEED_A;
            job_in   = J_SEED_A;
            phase_in = 2'd0;
            ksel_in  = 1'b0;
            state_in = S_MUL;
         end
         S_SEED_B: begin
            cmd.op   = ctbh_pkg::OP_SEED_B;
            job_in   = J_SEED_B;
            phase_in = 2'd0;
            ksel_in  = 1'b0;
            state_in = S_MUL;
         end
         S_SEED_C: begin
            cmd.op   = ctbh_pkg::OP_SEED_C;
            state_in = S_TOK1;
         end
         S_TOK1: begin
            cmd.op   = ctbh_pkg::OP_TOK1;
            state_in = S_TOK2;
         end
         S_TOK2: begin
            cmd.op   = ctbh_pkg::OP_TOK2;
            job_in   = J_TOK;
            phase_in = 2'd0;
            ksel_in  = 1'b0;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op   = ctbh_pkg::OP_MUL;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               if (!ksel_ff) begin
                  ksel_in = 1'b1;
               end else begin
                  case (job_ff)
                     J_SEED_A: state_in = S_SEED_B;
                     J_SEED_B: state_in = S_SEED_C;
                     default:  state_in = S_FIN;
                  endcase
               end
            end
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.op   = ctbh_pkg::OP_FIN;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 2'd0;
         ksel_ff  <= 1'b0;
         job_ff   <= J_SEED_A;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         ksel_ff  <= ksel_in;
         job_ff   <= job_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

>>> sv/chained_token_block_hash.sv
// top level of the chained token block hash
// Chained token block hash: takes one 32-bit token per request transaction, folds it into
// the hash of the current block and, when the block holds tokens_per_block tokens, returns
// one response transaction with the block's 64-bit hash (never zero) and its index within
// the sequence. A set seq_start restarts the chain and drops any partial block; a partial
// block is never returned. Every 64-bit multiply is built from three 32x32 partial
// products on a single shared multiplier, and one finalizer mix uses two such multiplies.
// A token that continues a block passes through accept, the fold steps TOK1 and TOK2, one
// mix and finish before the next request can be taken; the first token of a block also
// computes the block seed with two more mixes. The finish step waits only if a previous
// response is still held by a stalled consumer; requests are taken while a response
// waits. Configuration writes are always ready and must only be issued while no request
// is in flight.
`default_nettype none

module chained_token_block_hash #(
   parameter int MAX_BLOCK_TOKENS = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request transactions
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire ctbh_pkg::req_type                  req_payload,
   // response transactions
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output ctbh_pkg::rsp_type                       rsp_payload,
   // register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [ctbh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [63:0]                        csr_data
);

   ctbh_pkg::cmd_type    cmd;
   ctbh_pkg::status_type status;

   // register writes land directly in the registers, so the port never holds off
   assign csr_ready = 1'b1;

   // sequencer: seed mixes on a block's first token, fold and mix per token
   ctbh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hash state, shared multiplier and the response register
   ctbh_dpath #(
      .MAX_BLOCK_TOKENS (MAX_BLOCK_TOKENS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_we      (csr_valid & csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`include "chained_token_block_hash_assert.svh"

   // once a request is taken the block is busy for at least the next cycle
   `CTBH_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // a zero hash is always replaced before it leaves
   `CTBH_ASSERT_SAME(a_hash_nonzero, rsp_valid, rsp_payload.block_hash != 64'd0)
   // a new response only appears at the end of a request in flight
   `CTBH_ASSERT_SAME(a_rsp_from_work, $rose(rsp_valid), $past(req_stall))

endmodule

`default_nettype wire
